// ===== design/igf_pkg.sv =====
// ----------------------------------------------------------------------------
// igf_pkg
// Shared types, constants and helpers of the interface gradient flux block.
// ----------------------------------------------------------------------------
package igf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_WIDTH  = 48;
    localparam int MAG_WIDTH  = OUT_WIDTH - 1;

    localparam logic [MAG_WIDTH-1:0]  OUT_MAX  = {MAG_WIDTH{1'b1}};
    localparam logic [DATA_WIDTH-2:0] AREA_MAX = {(DATA_WIDTH-1){1'b1}};

    // request kinds on the input stream
    typedef enum logic [1:0] {
        OP_HEADER    = 2'd0,
        OP_CENTRE    = 2'd1,
        OP_NEIGHBOUR = 2'd2
    } op_t;

    typedef enum logic [20:0] {
        ST_IDLE   = 21'h000001,
        ST_H_SQ   = 21'h000002,
        ST_H_ROOT = 21'h000004,
        ST_H_POST = 21'h000008,
        ST_H_DIV  = 21'h000010,
        ST_H_UN   = 21'h000020,
        ST_N_SQ   = 21'h000040,
        ST_N_DOT  = 21'h000080,
        ST_N_ROOT = 21'h000100,
        ST_N_POST = 21'h000200,
        ST_N_COS  = 21'h000400,
        ST_N_CMP  = 21'h000800,
        ST_N_GRAD = 21'h001000,
        ST_N_GEND = 21'h002000,
        ST_N_END  = 21'h004000,
        ST_F_START = 21'h008000,
        ST_F_MUL1 = 21'h010000,
        ST_F_MUL2 = 21'h020000,
        ST_F_DIV  = 21'h040000,
        ST_F_FPV  = 21'h080000,
        ST_F_OUT  = 21'h100000
    } state_t;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic [1:0]       sh;
    } prescale_t;

    // shift a vector down until every magnitude is below 2^31
    function automatic prescale_t prescale(input logic [2:0][32:0] v);
        prescale_t       r;
        logic [2:0][32:0] m;
        logic [32:0]     t;
        logic            any32;
        logic            any31;
        any32 = 1'b0;
        any31 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            m[i]     = v[i][32] ? (~v[i] + 33'd1) : v[i];
            r.neg[i] = v[i][32];
            any32    = any32 | m[i][32];
            any31    = any31 | m[i][31];
        end
        r.sh = any32 ? 2'd2 : (any31 ? 2'd1 : 2'd0);
        for (int i = 0; i < 3; i++) begin
            t        = m[i] >> r.sh;
            r.mag[i] = t[30:0];
        end
        return r;
    endfunction

endpackage

// ===== design/interface_gradient_flux.sv =====
// ----------------------------------------------------------------------------
// interface_gradient_flux
// Per-cell interface gradient and diffusive flux from a stream of requests.
// ----------------------------------------------------------------------------
// A cell arrives as a header request (normal, boundary value, diffusivity,
// marked bit), a centre request (centre, volume) and a run of neighbour
// requests; tlast closes the cell on a centre or neighbour request and then
// one result is produced (flux, source decrement, flux per volume, valid and
// saturated flags). All math runs on one 32x32 multiplier with an 82-bit
// accumulator, one bit-serial restoring divider and one bit-serial square
// root, stepped by a one-hot sequencer; s_tready is high only while idle.
// Work per request: a centre request only loads the centre and volume; a header
// runs a 3-term sum of squares, a 32-step root and three 47-step divides (none
// for a zero normal); a neighbour runs two 3-term sums, a root and at most a
// 50-step cosine divide and a 65-step gradient divide; a valid cell end adds two
// 2-term products and a 78-step divide, a not-valid one only fills the output. A
// finished result sits in the output register, so the next request is accepted
// while it waits; a second cell end stalls until the first result is taken.
// ----------------------------------------------------------------------------
module interface_gradient_flux
    import igf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x[31:0] vec_y[63:32] vec_z[95:64] scalar_value[127:96]
    // diffusivity[159:128] cell_marked[160], zero pad above
    input  logic [167:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,   // last_of_cell
    output logic         m_tvalid,
    input  logic         m_tready,
    // flux[47:0] source_delta[95:48] flux_per_volume[143:96]
    output logic [143:0] m_tdata,
    // result_valid[0] saturated[1]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data   // flip_normal
);

    // ---------------- control ----------------
    state_t      state_reg, state_next;
    logic        flip_reg, flip_next;
    logic        active_reg, active_next;
    logic        found_reg, found_next;
    logic        clamp_reg, clamp_next;     // area clamp in this cell
    logic        gclamp_reg, gclamp_next;   // chosen gradient clamped
    logic        mvalid_reg, mvalid_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [1:0]  hidx_reg, hidx_next;

    // ---------------- cell state ----------------
    logic signed [2:0][17:0] un_reg, un_next;
    logic [30:0]             area_reg, area_next;
    logic [2:0][31:0]        centre_reg, centre_next;
    logic [31:0]             bound_reg, bound_next;
    logic [31:0]             diff_reg, diff_next;
    logic [31:0]             vol_reg, vol_next;
    logic [31:0]             bcos_reg, bcos_next;
    logic [47:0]             bgrad_reg, bgrad_next;

    // ---------------- working registers ----------------
    logic [2:0][30:0] vmag_reg, vmag_next;
    logic [2:0]       vneg_reg, vneg_next;
    logic [1:0]       sh_reg, sh_next;
    logic             marked_reg, marked_next;
    logic             last_reg, last_next;
    logic [31:0]      scal_reg, scal_next;
    logic [81:0]      acc_reg, acc_next;
    logic [63:0]      prod_reg, prod_next;
    logic             pneg_reg, pneg_next;
    logic             psh_reg, psh_next;
    logic [49:0]      dot_reg, dot_next;
    logic [63:0]      sqx_reg, sqx_next;
    logic [63:0]      sqr_reg, sqr_next;
    logic [63:0]      sqb_reg, sqb_next;
    logic [48:0]      rem_reg, rem_next;
    logic [79:0]      num_reg, num_next;
    logic [79:0]      q_reg, q_next;
    logic [48:0]      den_reg, den_next;
    logic             gneg_reg, gneg_next;
    logic             fneg_reg, fneg_next;
    logic [46:0]      fm_reg, fm_next;
    logic [46:0]      sm_reg, sm_next;
    logic [46:0]      pm_reg, pm_next;
    logic             fsat_reg, fsat_next;
    logic             fvalid_reg, fvalid_next;
    logic [47:0]      oflux_reg, oflux_next;
    logic [47:0]      osrc_reg, osrc_next;
    logic [47:0]      ofpv_reg, ofpv_next;
    logic             oval_reg, oval_next;
    logic             osat_reg, osat_next;

    // ---------------- input decode ----------------
    logic [2:0][31:0] in_vec;
    logic [31:0]      in_scalar;
    logic [31:0]      in_diff;
    logic             in_marked;
    logic             in_fire;
    logic [2:0][32:0] pre_in;
    prescale_t        pre;

    assign in_vec[0] = s_tdata[31:0];
    assign in_vec[1] = s_tdata[63:32];
    assign in_vec[2] = s_tdata[95:64];
    assign in_scalar = s_tdata[127:96];
    assign in_diff   = s_tdata[159:128];
    assign in_marked = s_tdata[160];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // header takes the normal as is, a neighbour its offset from the centre
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s_tuser == OP_HEADER) begin
                pre_in[i] = {in_vec[i][31], in_vec[i]};
            end else begin
                pre_in[i] = {in_vec[i][31], in_vec[i]} - {centre_reg[i][31], centre_reg[i]};
            end
        end
        pre = prescale(pre_in);
    end

    // ---------------- shared multiply-accumulate ----------------
    logic [1:0]  mac_idx;
    logic [1:0]  mac_sel;
    logic [1:0]  mac_terms;
    logic [31:0] mac_a, mac_b;
    logic        mac_neg, mac_sh;
    logic [81:0] mac_term, mac_sum;
    logic        mac_last;
    logic [46:0] gmag;
    logic [31:0] dmag;
    logic [2:0][16:0] unmag;

    assign mac_idx = cnt_reg[1:0];
    assign mac_sel = (mac_idx == 2'd3) ? 2'd0 : mac_idx;
    assign gmag    = bgrad_reg[47] ? 47'(-bgrad_reg) : bgrad_reg[46:0];
    assign dmag    = diff_reg[31] ? (~diff_reg + 32'd1) : diff_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unmag[i] = un_reg[i][17] ? 17'(-un_reg[i]) : un_reg[i][16:0];
        end
    end

    always_comb begin
        mac_a     = '0;
        mac_b     = '0;
        mac_neg   = 1'b0;
        mac_sh    = 1'b0;
        mac_terms = 2'd3;
        case (state_reg)
            ST_H_SQ, ST_N_SQ: begin
                mac_a = {1'b0, vmag_reg[mac_sel]};
                mac_b = {1'b0, vmag_reg[mac_sel]};
            end
            ST_N_DOT: begin
                mac_a   = {1'b0, vmag_reg[mac_sel]};
                mac_b   = {15'd0, unmag[mac_sel]};
                mac_neg = vneg_reg[mac_sel] ^ un_reg[mac_sel][17];
            end
            ST_F_MUL1: begin
                mac_terms = 2'd2;
                mac_sh    = (mac_idx != 2'd0);
                mac_a     = mac_sh ? {17'd0, gmag[46:32]} : gmag[31:0];
                mac_b     = dmag;
            end
            ST_F_MUL2: begin
                mac_terms = 2'd2;
                mac_sh    = (mac_idx != 2'd0);
                mac_a     = mac_sh ? {17'd0, fm_reg[46:32]} : fm_reg[31:0];
                mac_b     = {1'b0, area_reg};
            end
            default: begin
                mac_terms = 2'd3;
            end
        endcase
    end

    assign mac_term = psh_reg ? {prod_reg[49:0], 32'd0} : {18'd0, prod_reg};
    assign mac_sum  = pneg_reg ? (acc_reg - mac_term) : (acc_reg + mac_term);
    assign mac_last = (mac_idx == mac_terms);

    // ---------------- shared square root step ----------------
    logic [64:0] sq_trial;
    logic        sq_ge;

    assign sq_trial = {1'b0, sqr_reg} + {1'b0, sqb_reg};
    assign sq_ge    = ({1'b0, sqx_reg} >= sq_trial);

    // ---------------- shared divider step ----------------
    logic [49:0] dv_rem2;
    logic        dv_ge;
    logic [49:0] dv_diff;

    assign dv_rem2 = {rem_reg, num_reg[cnt_reg]};
    assign dv_ge   = (dv_rem2 >= {1'b0, den_reg});
    assign dv_diff = dv_rem2 - {1'b0, den_reg};

    // ---------------- helpers ----------------
    logic [31:0] root;
    logic [33:0] area_sh;
    logic [16:0] udiv;
    logic [1:0]  hidx_inc;
    logic [49:0] dot_mag;
    logic [50:0] cos_val;
    logic [32:0] delta;
    logic [32:0] delta_mag;
    logic [78:0] p1;
    logic [77:0] p2;
    logic [31:0] vmag_vol;

    assign root      = sqr_reg[31:0];
    assign area_sh   = {2'b0, root} << sh_reg;
    assign udiv      = q_reg[16:0];
    assign hidx_inc  = hidx_reg + 2'd1;
    assign dot_mag   = dot_reg[49] ? (~dot_reg + 50'd1) : dot_reg;
    assign cos_val   = dot_reg[49] ? (~{1'b0, q_reg[49:0]} + 51'd1) : {1'b0, q_reg[49:0]};
    assign delta     = {scal_reg[31], scal_reg} - {bound_reg[31], bound_reg};
    assign delta_mag = delta[32] ? (~delta + 33'd1) : delta;
    assign p1        = mac_sum[78:0];
    assign p2        = mac_sum[77:0];
    assign vmag_vol  = vol_reg[31] ? (~vol_reg + 32'd1) : vol_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next  = state_reg;
        flip_next   = flip_reg;
        active_next = active_reg;
        found_next  = found_reg;
        clamp_next  = clamp_reg;
        gclamp_next = gclamp_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cnt_next    = cnt_reg;
        hidx_next   = hidx_reg;
        un_next     = un_reg;
        area_next   = area_reg;
        centre_next = centre_reg;
        bound_next  = bound_reg;
        diff_next   = diff_reg;
        vol_next    = vol_reg;
        bcos_next   = bcos_reg;
        bgrad_next  = bgrad_reg;
        vmag_next   = vmag_reg;
        vneg_next   = vneg_reg;
        sh_next     = sh_reg;
        marked_next = marked_reg;
        last_next   = last_reg;
        scal_next   = scal_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        pneg_next   = pneg_reg;
        psh_next    = psh_reg;
        dot_next    = dot_reg;
        sqx_next    = sqx_reg;
        sqr_next    = sqr_reg;
        sqb_next    = sqb_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        q_next      = q_reg;
        den_next    = den_reg;
        gneg_next   = gneg_reg;
        fneg_next   = fneg_reg;
        fm_next     = fm_reg;
        sm_next     = sm_reg;
        pm_next     = pm_reg;
        fsat_next   = fsat_reg;
        fvalid_next = fvalid_reg;
        oflux_next  = oflux_reg;
        osrc_next   = osrc_reg;
        ofpv_next   = ofpv_reg;
        oval_next   = oval_reg;
        osat_next   = osat_reg;

        if (cfg_valid) begin
            flip_next = cfg_data;
        end

        // MAC runs whenever a MAC state is active
        if (state_reg == ST_H_SQ || state_reg == ST_N_SQ || state_reg == ST_N_DOT ||
            state_reg == ST_F_MUL1 || state_reg == ST_F_MUL2) begin
            if (mac_idx < mac_terms) begin
                prod_next = mac_a * mac_b;
                pneg_next = mac_neg;
                psh_next  = mac_sh;
            end
            if (mac_idx != 2'd0) begin
                acc_next = mac_sum;
            end
            cnt_next = cnt_reg + 7'd1;
        end

        if (state_reg == ST_H_ROOT || state_reg == ST_N_ROOT) begin
            if (sq_ge) begin
                sqx_next = sqx_reg - sq_trial[63:0];
                sqr_next = (sqr_reg >> 1) + sqb_reg;
            end else begin
                sqr_next = sqr_reg >> 1;
            end
            sqb_next = sqb_reg >> 2;
            cnt_next = cnt_reg + 7'd1;
        end

        if (state_reg == ST_H_DIV || state_reg == ST_N_COS || state_reg == ST_N_GRAD ||
            state_reg == ST_F_DIV) begin
            rem_next = dv_ge ? dv_diff[48:0] : dv_rem2[48:0];
            q_next   = {q_reg[78:0], dv_ge};
            cnt_next = cnt_reg - 7'd1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    vmag_next   = pre.mag;
                    vneg_next   = pre.neg;
                    sh_next     = pre.sh;
                    scal_next   = in_scalar;
                    last_next   = s_tlast;
                    marked_next = in_marked;
                    acc_next    = '0;
                    cnt_next    = '0;
                    case (s_tuser)
                        OP_HEADER: begin
                            active_next = 1'b0;
                            found_next  = 1'b0;
                            bcos_next   = {1'b1, 31'd0};
                            bgrad_next  = '0;
                            gclamp_next = 1'b0;
                            clamp_next  = 1'b0;
                            bound_next  = in_scalar;
                            diff_next   = in_diff;
                            state_next  = ST_H_SQ;
                        end
                        OP_CENTRE: begin
                            centre_next = in_vec;
                            vol_next    = in_scalar;
                            state_next  = s_tlast ? ST_F_START : ST_IDLE;
                        end
                        OP_NEIGHBOUR: begin
                            state_next = ST_N_SQ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_H_SQ: begin
                if (mac_last) begin
                    sqx_next   = mac_sum[63:0];
                    sqr_next   = '0;
                    sqb_next   = 64'd1 << 62;
                    cnt_next   = '0;
                    state_next = ST_H_ROOT;
                end
            end
            ST_H_ROOT: begin
                if (cnt_reg == 7'd31) begin
                    state_next = ST_H_POST;
                end
            end
            ST_H_POST: begin
                if (root == 32'd0) begin
                    un_next    = '0;
                    area_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    if (area_sh > {3'd0, AREA_MAX}) begin
                        area_next  = AREA_MAX;
                        clamp_next = 1'b1;
                    end else begin
                        area_next = area_sh[30:0];
                    end
                    num_next   = {33'd0, vmag_reg[0], {FRAC_BITS{1'b0}}};
                    den_next   = {17'd0, root};
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = 7'd46;
                    hidx_next  = '0;
                    state_next = ST_H_DIV;
                end
            end
            ST_H_DIV: begin
                if (cnt_reg == 7'd0) begin
                    state_next = ST_H_UN;
                end
            end
            ST_H_UN: begin
                un_next[hidx_reg] = (vneg_reg[hidx_reg] ^ flip_reg) ?
                                    (~{1'b0, udiv} + 18'd1) : {1'b0, udiv};
                if (hidx_reg == 2'd2) begin
                    active_next = marked_reg;
                    state_next  = ST_IDLE;
                end else begin
                    hidx_next  = hidx_inc;
                    num_next   = {33'd0, vmag_reg[hidx_inc], {FRAC_BITS{1'b0}}};
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = 7'd46;
                    state_next = ST_H_DIV;
                end
            end
            ST_N_SQ: begin
                if (mac_last) begin
                    sqx_next   = mac_sum[63:0];
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_N_DOT;
                end
            end
            ST_N_DOT: begin
                if (mac_last) begin
                    dot_next   = mac_sum[49:0];
                    sqr_next   = '0;
                    sqb_next   = 64'd1 << 62;
                    cnt_next   = '0;
                    state_next = ST_N_ROOT;
                end
            end
            ST_N_ROOT: begin
                if (cnt_reg == 7'd31) begin
                    state_next = ST_N_POST;
                end
            end
            ST_N_POST: begin
                // zero-length offset: neighbour skipped
                if (root == 32'd0) begin
                    state_next = ST_N_END;
                end else begin
                    num_next   = {30'd0, dot_mag};
                    den_next   = {17'd0, root};
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = 7'd49;
                    state_next = ST_N_COS;
                end
            end
            ST_N_COS: begin
                if (cnt_reg == 7'd0) begin
                    state_next = ST_N_CMP;
                end
            end
            ST_N_CMP: begin
                if ($signed(cos_val) > $signed({{19{bcos_reg[31]}}, bcos_reg})) begin
                    bcos_next   = cos_val[31:0];
                    found_next  = 1'b1;
                    gclamp_next = 1'b0;
                    gneg_next   = delta[32] ^ dot_reg[49];
                    if (dot_reg == 50'd0) begin
                        // zero distance along the normal
                        gclamp_next = 1'b1;
                        if (delta_mag == 33'd0) begin
                            bgrad_next = '0;
                        end else if (delta[32]) begin
                            bgrad_next = ~{1'b0, OUT_MAX} + 48'd1;
                        end else begin
                            bgrad_next = {1'b0, OUT_MAX};
                        end
                        state_next = ST_N_END;
                    end else begin
                        num_next   = {47'd0, delta_mag} << (6'd2 * 6'(FRAC_BITS) - {4'd0, sh_reg});
                        den_next   = dot_mag[48:0];
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = 7'd64;
                        state_next = ST_N_GRAD;
                    end
                end else begin
                    state_next = ST_N_END;
                end
            end
            ST_N_GRAD: begin
                if (cnt_reg == 7'd0) begin
                    state_next = ST_N_GEND;
                end
            end
            ST_N_GEND: begin
                if (q_reg[79:47] != '0) begin
                    gclamp_next = 1'b1;
                    bgrad_next  = gneg_reg ? (~{1'b0, OUT_MAX} + 48'd1) : {1'b0, OUT_MAX};
                end else begin
                    bgrad_next  = gneg_reg ? (~{1'b0, q_reg[46:0]} + 48'd1) : {1'b0, q_reg[46:0]};
                end
                state_next = ST_N_END;
            end
            ST_N_END: begin
                state_next = last_reg ? ST_F_START : ST_IDLE;
            end
            ST_F_START: begin
                fvalid_next = active_reg && found_reg;
                fsat_next   = 1'b0;
                fneg_next   = bgrad_reg[47] ^ diff_reg[31];
                acc_next    = '0;
                cnt_next    = '0;
                if (active_reg && found_reg) begin
                    state_next = ST_F_MUL1;
                end else begin
                    fm_next    = '0;
                    sm_next    = '0;
                    pm_next    = '0;
                    state_next = ST_F_OUT;
                end
            end
            ST_F_MUL1: begin
                if (mac_last) begin
                    if (p1[78:63] != '0) begin
                        fm_next   = OUT_MAX;
                        fsat_next = 1'b1;
                    end else begin
                        fm_next = p1[62:16];
                    end
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_F_MUL2;
                end
            end
            ST_F_MUL2: begin
                if (mac_last) begin
                    if (p2[77:63] != '0) begin
                        sm_next   = OUT_MAX;
                        fsat_next = 1'b1;
                    end else begin
                        sm_next = p2[62:16];
                    end
                    if (vmag_vol == 32'd0) begin
                        fsat_next  = 1'b1;
                        pm_next    = (p2 != '0) ? OUT_MAX : '0;
                        state_next = ST_F_OUT;
                    end else begin
                        num_next   = {2'd0, p2};
                        den_next   = {17'd0, vmag_vol};
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = 7'd77;
                        state_next = ST_F_DIV;
                    end
                end
            end
            ST_F_DIV: begin
                if (cnt_reg == 7'd0) begin
                    state_next = ST_F_FPV;
                end
            end
            ST_F_FPV: begin
                if (q_reg[79:47] != '0) begin
                    pm_next   = OUT_MAX;
                    fsat_next = 1'b1;
                end else begin
                    pm_next = q_reg[46:0];
                end
                state_next = ST_F_OUT;
            end
            ST_F_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    oflux_next  = fneg_reg ? (~{1'b0, fm_reg} + 48'd1) : {1'b0, fm_reg};
                    osrc_next   = fneg_reg ? {1'b0, sm_reg} : (~{1'b0, sm_reg} + 48'd1);
                    ofpv_next   = (fneg_reg ^ vol_reg[31]) ? (~{1'b0, pm_reg} + 48'd1)
                                                           : {1'b0, pm_reg};
                    oval_next   = fvalid_reg;
                    osat_next   = fvalid_reg && (fsat_reg || clamp_reg || gclamp_reg);
                    mvalid_next = 1'b1;
                    // cell closed
                    active_next = 1'b0;
                    found_next  = 1'b0;
                    bcos_next   = {1'b1, 31'd0};
                    bgrad_next  = '0;
                    gclamp_next = 1'b0;
                    clamp_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            flip_reg   <= 1'b0;
            active_reg <= 1'b0;
            found_reg  <= 1'b0;
            clamp_reg  <= 1'b0;
            gclamp_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            cnt_reg    <= '0;
            hidx_reg   <= '0;
            un_reg     <= '0;
            area_reg   <= '0;
            centre_reg <= '0;
            bound_reg  <= '0;
            diff_reg   <= '0;
            vol_reg    <= '0;
            bcos_reg   <= {1'b1, 31'd0};
            bgrad_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            flip_reg   <= flip_next;
            active_reg <= active_next;
            found_reg  <= found_next;
            clamp_reg  <= clamp_next;
            gclamp_reg <= gclamp_next;
            mvalid_reg <= mvalid_next;
            cnt_reg    <= cnt_next;
            hidx_reg   <= hidx_next;
            un_reg     <= un_next;
            area_reg   <= area_next;
            centre_reg <= centre_next;
            bound_reg  <= bound_next;
            diff_reg   <= diff_next;
            vol_reg    <= vol_next;
            bcos_reg   <= bcos_next;
            bgrad_reg  <= bgrad_next;
        end
    end

    always_ff @(posedge aclk) begin
        vmag_reg   <= vmag_next;
        vneg_reg   <= vneg_next;
        sh_reg     <= sh_next;
        marked_reg <= marked_next;
        last_reg   <= last_next;
        scal_reg   <= scal_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        pneg_reg   <= pneg_next;
        psh_reg    <= psh_next;
        dot_reg    <= dot_next;
        sqx_reg    <= sqx_next;
        sqr_reg    <= sqr_next;
        sqb_reg    <= sqb_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        q_reg      <= q_next;
        den_reg    <= den_next;
        gneg_reg   <= gneg_next;
        fneg_reg   <= fneg_next;
        fm_reg     <= fm_next;
        sm_reg     <= sm_next;
        pm_reg     <= pm_next;
        fsat_reg   <= fsat_next;
        fvalid_reg <= fvalid_next;
        oflux_reg  <= oflux_next;
        osrc_reg   <= osrc_next;
        ofpv_reg   <= ofpv_next;
        oval_reg   <= oval_next;
        osat_reg   <= osat_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {ofpv_reg, osrc_reg, oflux_reg};
    assign m_tuser  = {osat_reg, oval_reg};

endmodule
